// ===== rtl/core/prpd_pkg.sv =====
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared types and constants for the packed run-length pixel decoder.
// ----------------------------------------------------------------------------
package prpd_pkg;

   // Row width limits and reset value
   localparam logic [12:0] ROW_WIDTH_MIN   = 13'd128;
   localparam logic [12:0] ROW_WIDTH_MAX   = 13'd4096;
   localparam logic [12:0] ROW_WIDTH_RESET = 13'd320;

   // Row counter saturates here
   localparam logic [11:0] ROW_Y_MAX = 12'hFFF;

   // Shared adder operations
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   // One output segment
   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] length;
      logic [10:0] color;
      logic        last;
   } seg_type;

endpackage

// ===== rtl/core/prpd_alu.sv =====
// ----------------------------------------------------------------------------
// prpd_alu
// Shared 14-bit add/subtract unit used by the segment sequencer.
// ----------------------------------------------------------------------------
module prpd_alu (
   input  logic [13:0] op_a,
   input  logic [13:0] op_b,
   input  logic        op_sel,
   output logic [13:0] result
);
   import prpd_pkg::*;

   logic [13:0] b_eff;
   logic [13:0] carry_in;

   // a - b done as a + ~b + 1
   assign b_eff    = (op_sel == ALU_SUB) ? ~op_b : op_b;
   assign carry_in = (op_sel == ALU_SUB) ? 14'd1 : 14'd0;
   assign result   = op_a + b_eff + carry_in;

endmodule

// ===== rtl/core/prpd_seq.sv =====
// ----------------------------------------------------------------------------
// prpd_seq
// Byte gathering, cursor and segment sequencer around the shared adder.
// ----------------------------------------------------------------------------
module prpd_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic [12:0]       width,
   input  logic              slot_free,
   output logic              seg_valid,
   output prpd_pkg::seg_type seg
);
   import prpd_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PREP     = 3'd1;
   localparam logic [2:0] ST_LIT_A    = 3'd2;
   localparam logic [2:0] ST_LIT_B    = 3'd3;
   localparam logic [2:0] ST_RUN_CUT  = 3'd4;
   localparam logic [2:0] ST_RUN_TAIL = 3'd5;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   logic [2:0]  state_ff,  state_in;
   logic [1:0]  phase_ff,  phase_in;
   logic [7:0]  b0_ff,     b0_in;
   logic [7:0]  b1_ff,     b1_in;
   logic [11:0] v1_ff,     v1_in;
   logic [11:0] left_ff,   left_in;   // run length left, or second literal
   logic [11:0] cx_ff,     cx_in;
   logic [11:0] cy_ff,     cy_in;
   logic [12:0] rem_ff,    rem_in;    // pixels left in current row

   logic [13:0] alu_a, alu_b, alu_res;
   logic        alu_op;
   logic [11:0] cy_inc;
   logic        past_end;
   logic        lit_wrap;

   prpd_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sel (alu_op),
      .result (alu_res)
   );

   assign cy_inc    = (cy_ff == ROW_Y_MAX) ? cy_ff : cy_ff + 12'd1;
   assign past_end  = alu_res[13] || (alu_res == 14'd0);
   assign lit_wrap  = (alu_res >= {1'b0, width});
   assign req_ready = (state_ff == ST_IDLE);

   // operand select for the shared adder
   always_comb begin
      alu_a  = 14'd0;
      alu_b  = 14'd0;
      alu_op = ALU_ADD;
      case (state_ff)
         ST_PREP: begin
            alu_a  = {1'b0, width};
            alu_b  = {2'b00, cx_ff};
            alu_op = ALU_SUB;
         end
         ST_LIT_A, ST_LIT_B: begin
            alu_a  = {2'b00, cx_ff};
            alu_b  = 14'd1;
         end
         ST_RUN_CUT: begin
            alu_a  = {2'b00, left_ff};
            alu_b  = {1'b0, rem_ff};
            alu_op = ALU_SUB;
         end
         ST_RUN_TAIL: begin
            alu_a  = {2'b00, cx_ff};
            alu_b  = {2'b00, left_ff};
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      b0_in      = b0_ff;
      b1_in      = b1_ff;
      v1_in      = v1_ff;
      left_in    = left_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rem_in     = rem_ff;
      seg_valid  = 1'b0;
      seg.x      = cx_ff;
      seg.y      = cy_ff;
      seg.length = 13'd1;
      seg.color  = v1_ff[10:0];
      seg.last   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (phase_ff)
                  PH_FIRST: begin
                     b0_in    = req_data_byte;
                     phase_in = PH_SECOND;
                  end
                  PH_SECOND: begin
                     b1_in    = req_data_byte;
                     phase_in = PH_THIRD;
                  end
                  default: begin
                     phase_in = PH_FIRST;
                     v1_in    = {b0_ff, b1_ff[7:4]};
                     left_in  = {b1_ff[3:0], req_data_byte};
                     state_in = ST_PREP;
                  end
               endcase
            end
         end
         ST_PREP: begin
            if (past_end) begin
               cx_in  = 12'd0;
               cy_in  = cy_inc;
               rem_in = width;
            end else begin
               rem_in = alu_res[12:0];
            end
            if (v1_ff[11]) begin
               state_in = ST_LIT_A;
            end else if (left_ff == 12'd0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RUN_CUT;
            end
         end
         ST_LIT_A, ST_LIT_B: begin
            if (slot_free) begin
               seg_valid = 1'b1;
               if (state_ff == ST_LIT_B) begin
                  seg.color = left_ff[10:0];
                  seg.last  = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in  = ST_LIT_B;
               end
               if (lit_wrap) begin
                  cx_in = 12'd0;
                  cy_in = cy_inc;
               end else begin
                  cx_in = alu_res[11:0];
               end
            end
         end
         ST_RUN_CUT: begin
            if (slot_free) begin
               seg_valid = 1'b1;
               if (!alu_res[13]) begin
                  // run reaches the row end: cut here, go on at next row
                  seg.length = rem_ff;
                  seg.last   = (alu_res == 14'd0);
                  left_in    = alu_res[11:0];
                  cx_in      = 12'd0;
                  cy_in      = cy_inc;
                  rem_in     = width;
                  state_in   = (alu_res == 14'd0) ? ST_IDLE : ST_RUN_CUT;
               end else begin
                  seg.length = {1'b0, left_ff};
                  seg.last   = 1'b1;
                  state_in   = ST_RUN_TAIL;
               end
            end
         end
         ST_RUN_TAIL: begin
            cx_in    = alu_res[11:0];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FIRST;
         b0_ff    <= 8'd0;
         b1_ff    <= 8'd0;
         cx_ff    <= 12'd0;
         cy_ff    <= 12'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      v1_ff   <= v1_in;
      left_ff <= left_in;
      rem_ff  <= rem_in;
   end

endmodule

// ===== rtl/core/packed_rle_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// packed_rle_pixel_decoder_unit
// Unpacks 3-byte groups into literal pixel pairs or colour runs and emits
// them as horizontal segments, wrapping runs at the row width.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  req_     | in        | req_valid/ready    | data_byte (one word per byte)
//  rsp_     | out       | rsp_valid/ready    | seg_x, seg_y, seg_length,
//           |           |                    | seg_color, last_of_item
//  csr_     | in        | csr_write_enable   | row_width (13 b, no read-back)
//
// Sequence: the first and second byte of a group are stored as accepted. The
// third byte is followed by a row-end check, then the segments (two for a
// literal pair, k for a run split over k rows), then a cursor update when a
// run ends inside a row. No new byte is accepted until the sequence is done.
// Reset: synchronous; row_width returns to 320, cursor to (0,0), group to
// its first byte. No clearing pass.
// Stalls: a segment is emitted only when the output register is free or
// being taken; a low rsp_ready with a word waiting freezes the sequencer.
//
module packed_rle_pixel_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // segment output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_seg_x,
   output logic [11:0] rsp_seg_y,
   output logic [12:0] rsp_seg_length,
   output logic [10:0] rsp_seg_color,
   output logic        rsp_last_of_item,
   // configuration
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data
);
   import prpd_pkg::*;

   logic [12:0] row_width_ff;
   logic [12:0] width_eff;
   logic        rsp_valid_ff, rsp_valid_in;
   seg_type     seg_ff;
   seg_type     seg_new;
   logic        seg_new_valid;
   logic        slot_free;

   // row width register
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else if (csr_write_enable) begin
         row_width_ff <= csr_write_data;
      end
   end

   // clamp into the legal row range where it is used
   always_comb begin
      if (row_width_ff < ROW_WIDTH_MIN) begin
         width_eff = ROW_WIDTH_MIN;
      end else if (row_width_ff > ROW_WIDTH_MAX) begin
         width_eff = ROW_WIDTH_MAX;
      end else begin
         width_eff = row_width_ff;
      end
   end

   // output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   prpd_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .width         (width_eff),
      .slot_free     (slot_free),
      .seg_valid     (seg_new_valid),
      .seg           (seg_new)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seg_new_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds while stalled; loads only with a new segment
   always_ff @(posedge clock) begin
      if (seg_new_valid) begin
         seg_ff <= seg_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seg_x        = seg_ff.x;
   assign rsp_seg_y        = seg_ff.y;
   assign rsp_seg_length   = seg_ff.length;
   assign rsp_seg_color    = seg_ff.color;
   assign rsp_last_of_item = seg_ff.last;

endmodule

// ===== rtl/core/prpd_checker.sv =====
// ----------------------------------------------------------------------------
// prpd_checker
// Port-level checks on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module prpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_seg_x,
   input logic [11:0] rsp_seg_y,
   input logic [12:0] rsp_seg_length,
   input logic [10:0] rsp_seg_color,
   input logic        rsp_last_of_item,
   input logic        csr_write_enable,
   input logic [12:0] csr_write_data
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg_x)
         && $stable(rsp_seg_y) && $stable(rsp_seg_length)
         && $stable(rsp_seg_color) && $stable(rsp_last_of_item))
      else $error("rsp word changed while stalled");

   // no empty segment
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seg_length != 13'd0)
      else $error("zero-length segment");

   // a segment never runs past the widest row
   a_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_seg_x} + {1'b0, rsp_seg_length}) <= 14'd4096)
      else $error("segment crosses row limit");

   // out of reset: ready for a byte and nothing pending
   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind packed_rle_pixel_decoder_unit prpd_checker u_prpd_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed run-length pixel decoder: a table of
// directed bytes, then random 3-byte groups over several row widths, each
// segment checked against an in-bench decoder model or a typed expectation.
// ----------------------------------------------------------------------------
module tb;
   import prpd_pkg::*;

   // Run length is bounded by a cycle count; well above the slowest legal run
   localparam int CYCLE_LIMIT = 400000;
   // Cycles allowed after the last segment for the block to settle
   localparam int SETTLE_CYCLES = 8;
   // Long receiver hold-off, so the output backs up into the byte input
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int GROUPS_PER_PHASE = 3;

   localparam seg_type NO_SEG = '0;

   typedef enum logic {ROW_BYTE, ROW_WIDTH} row_kind_type;

   // One row of the directed table. typed_count < 0: the model decides the
   // expected segments; otherwise the typed segments are the expectation.
   typedef struct {
      row_kind_type kind;
      logic [12:0]  value;
      int           typed_count;
      seg_type      typed_a;
      seg_type      typed_b;
   } stim_row_type;

   localparam int N_DIRECTED = 26;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_seg_x;
   logic [11:0] rsp_seg_y;
   logic [12:0] rsp_seg_length;
   logic [10:0] rsp_seg_color;
   logic        rsp_last_of_item;
   logic        csr_write_enable;
   logic [12:0] csr_write_data;

   // Decoder model state
   logic [1:0]  grp_phase = 2'd0;
   logic [7:0]  grp_b0    = 8'd0;
   logic [7:0]  grp_b1    = 8'd0;
   int          cur_x     = 0;
   int          cur_y     = 0;
   logic [12:0] width_reg = ROW_WIDTH_RESET;

   seg_type     decoded_segs[$];   // segments caused by the latest byte
   seg_type     pending_segs[$];   // segments still owed by the block

   int          mismatch_count = 0;
   int          segs_seen      = 0;
   int          cycle_count    = 0;
   int          burst_left     = 0;
   bit          sender_no_gaps = 1'b1;
   bit          hold_req       = 1'b0;

   // Directed words. Typed expectations only where they are obvious:
   // straight after reset, at the colour extremes and for an empty run.
   stim_row_type directed_rows [N_DIRECTED] = '{
      // literal pair, both colours at the top of the palette
      '{ROW_BYTE, 13'h0FF, 0, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0FF, 0, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0FF, 2, '{12'd0, 12'd0, 13'd1, 11'd2047, 1'b0},
                              '{12'd1, 12'd0, 13'd1, 11'd2047, 1'b1}},
      // smallest literal header (2048), both colours zero
      '{ROW_BYTE, 13'h080, 0, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h000, 0, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h000, 2, '{12'd2, 12'd0, 13'd1, 11'd0, 1'b0},
                              '{12'd3, 12'd0, 13'd1, 11'd0, 1'b1}},
      // empty run: no segment, cursor stays put
      '{ROW_BYTE, 13'h000, 0, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h000, 0, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h000, 0, NO_SEG, NO_SEG},
      // longest run, top colour, wraps over a dozen rows
      '{ROW_BYTE, 13'h07F, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0FF, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0FF, -1, NO_SEG, NO_SEG},
      // run of 61 from column 259: ends exactly on the row end
      '{ROW_BYTE, 13'h015, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h050, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h03D, -1, NO_SEG, NO_SEG},
      // run of 200 leaves the cursor at column 200
      '{ROW_BYTE, 13'h000, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h010, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0C8, -1, NO_SEG, NO_SEG},
      // width below range (clamps to 128): cursor now past the row end
      '{ROW_WIDTH, 13'h0000, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0FF, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0F0, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h001, -1, NO_SEG, NO_SEG},
      // width above range (clamps to 4096), then a mid-size run
      '{ROW_WIDTH, 13'h1FFF, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h02A, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0AA, -1, NO_SEG, NO_SEG},
      '{ROW_BYTE, 13'h0AA, -1, NO_SEG, NO_SEG}
   };

   packed_rle_pixel_decoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_x        (rsp_seg_x),
      .rsp_seg_y        (rsp_seg_y),
      .rsp_seg_length   (rsp_seg_length),
      .rsp_seg_color    (rsp_seg_color),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------

   // Width as the block uses it: clamped to 128..4096
   function automatic int clamp_width(input logic [12:0] w);
      if (w < ROW_WIDTH_MIN) return int'(ROW_WIDTH_MIN);
      if (w > ROW_WIDTH_MAX) return int'(ROW_WIDTH_MAX);
      return int'(w);
   endfunction

   // Column 0 of the next row; the row counter sticks at its top
   function automatic void next_row();
      cur_x = 0;
      if (cur_y < ROW_Y_MAX) cur_y++;
   endfunction

   function automatic void add_seg(input int len, input logic [10:0] col);
      seg_type s;
      s.x      = 12'(cur_x);
      s.y      = 12'(cur_y);
      s.length = 13'(len);
      s.color  = col;
      s.last   = 1'b0;
      decoded_segs.push_back(s);
   endfunction

   // Advances the model by one byte; segments land in decoded_segs
   task automatic decode_byte(input logic [7:0] b);
      logic [11:0] v1;
      logic [11:0] v2;
      int          w;
      int          left;
      int          part;
      seg_type     s;
      decoded_segs.delete();
      case (grp_phase)
         2'd0: begin
            grp_b0    = b;
            grp_phase = 2'd1;
         end
         2'd1: begin
            grp_b1    = b;
            grp_phase = 2'd2;
         end
         default: begin
            grp_phase = 2'd0;
            v1 = {grp_b0, grp_b1[7:4]};
            v2 = {grp_b1[3:0], b};
            w  = clamp_width(width_reg);
            // width lowered mid-row: start the group on a fresh row
            if (cur_x >= w) next_row();
            if (v1[11]) begin
               // literal pair, one pixel each
               add_seg(1, v1[10:0]);
               cur_x++;
               if (cur_x >= w) next_row();
               add_seg(1, v2[10:0]);
               cur_x++;
               if (cur_x >= w) next_row();
            end else begin
               // run: cut at each row end, no empty tail segment
               left = int'(v2);
               while (cur_x + left >= w) begin
                  part = w - cur_x;
                  add_seg(part, v1[10:0]);
                  left -= part;
                  next_row();
               end
               if (left != 0) begin
                  add_seg(left, v1[10:0]);
                  cur_x += left;
               end
            end
            if (decoded_segs.size() != 0) begin
               s = decoded_segs.pop_back();
               s.last = 1'b1;
               decoded_segs.push_back(s);
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Byte sender: bursts of random length with random gaps between them.
   // Valid is never dropped between words of a burst.
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_no_gaps ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic feed_byte(input logic [7:0] b);
      send_byte(b);
      decode_byte(b);
      foreach (decoded_segs[i]) pending_segs.push_back(decoded_segs[i]);
   endtask

   // Drop valid, wait for every owed segment, then let the block settle.
   // The settle time covers a trailing group that gives no segment.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_segs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_row_width(input logic [12:0] w);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      width_reg = w;
   endtask

   // One 3-byte group. Mostly well-formed literals and runs, some aimed at
   // the row end, some empty, some plain noise. long_bias gives only the
   // longest runs, about 32 rows a group at the narrowest width, so the row
   // counter reaches its top in few groups.
   task automatic random_group(input bit long_bias);
      int          kind;
      int          w;
      int          cx;
      int          len;
      logic [11:0] v1;
      logic [11:0] v2;
      kind = $urandom_range(0, 9);
      if (long_bias) kind = 6;
      v1 = 12'($urandom_range(0, 2047));
      v2 = 12'($urandom_range(0, 300));
      case (kind)
         0, 1, 2: begin
            v1 = 12'($urandom_range(2048, 4095));
            v2 = 12'($urandom);
         end
         3, 4, 5: ;   // short run as drawn above
         6: v2 = 12'($urandom_range(long_bias ? 4000 : 1000, 4095));
         7: begin
            // land exactly on a row end, possibly a row or two further on
            w   = clamp_width(width_reg);
            cx  = (cur_x >= w) ? 0 : cur_x;
            len = w - cx + w * $urandom_range(0, 2);
            while (len > 4095 && len > w) len -= w;
            if (len > 4095) len = 4095;
            v2 = 12'(len);
         end
         8: v2 = 12'd0;
         default: begin
            v1 = 12'($urandom);
            v2 = 12'($urandom);
         end
      endcase
      feed_byte(v1[11:4]);
      feed_byte({v1[3:0], v2[11:8]});
      feed_byte(v2[7:0]);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH seg %0d %s: got %0d, expected %0d", segs_seen, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Segment checker: each accepted word against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : segment_check
      seg_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_segs.size() == 0) begin
            report_mismatch("with nothing pending, x", rsp_seg_x, -1);
         end else begin
            want = pending_segs.pop_front();
            if (rsp_seg_x !== want.x) report_mismatch("x", rsp_seg_x, want.x);
            if (rsp_seg_y !== want.y) report_mismatch("y", rsp_seg_y, want.y);
            if (rsp_seg_length !== want.length)
               report_mismatch("length", rsp_seg_length, want.length);
            if (rsp_seg_color !== want.color)
               report_mismatch("colour", rsp_seg_color, want.color);
            if (rsp_last_of_item !== want.last)
               report_mismatch("last", rsp_last_of_item, want.last);
         end
         segs_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: applies a randomly drawn stall pattern, redrawn as each one
   // runs out; a requested long hold-off is counted out here.
   // ------------------------------------------------------------------
   initial begin : receiver
      int stall_mode;
      int mode_left;
      int hold_left;
      int tick;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      tick       = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = 50;
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;                          // never stalls
               1: rsp_ready <= 1'($urandom_range(0, 1));      // coin toss
               2: rsp_ready <= ((tick % 4) == 0);             // one in four
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int guard;
      req_valid        <= 1'b0;
      req_data_byte    <= 8'd0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= ROW_WIDTH_RESET;
      reset            <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table, started at the reset width of 320
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WIDTH) begin
            set_row_width(directed_rows[i].value);
         end else if (directed_rows[i].typed_count < 0) begin
            feed_byte(directed_rows[i].value[7:0]);
         end else begin
            send_byte(directed_rows[i].value[7:0]);
            decode_byte(directed_rows[i].value[7:0]);   // keeps the model in step
            if (directed_rows[i].typed_count > 0) pending_segs.push_back(directed_rows[i].typed_a);
            if (directed_rows[i].typed_count > 1) pending_segs.push_back(directed_rows[i].typed_b);
         end
      end

      // Random phases over a spread of widths, extremes included.
      // Lowering the width between phases leaves the cursor past the row
      // end now and then.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_row_width(ROW_WIDTH_MAX);
            1: set_row_width(ROW_WIDTH_MIN);
            2: set_row_width(13'($urandom_range(128, 4096)));
            3: set_row_width(13'($urandom));                 // may be out of range
            default: set_row_width(13'($urandom_range(129, 700)));
         endcase
         sender_no_gaps = (ph == 0) || ($urandom_range(0, 3) == 0);
         // long receiver hold-off while the sender keeps offering bytes
         if (ph == 1) hold_req = 1'b1;
         for (int g = 0; g < GROUPS_PER_PHASE; g++) random_group(1'b0);
      end

      // Narrowest rows and long runs drive the row counter to its top,
      // then a mixed tail runs on the saturated row.
      set_row_width(13'($urandom_range(0, 127)));
      sender_no_gaps = 1'b0;
      guard = 0;
      while (cur_y < ROW_Y_MAX && guard < 400) begin
         random_group(1'b1);
         guard++;
      end
      for (int g = 0; g < 4; g++) random_group(1'b0);

      wait_idle();
      if (mismatch_count == 0 && pending_segs.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/prpd_pkg.sv
rtl/core/prpd_alu.sv
rtl/core/prpd_seq.sv
rtl/core/packed_rle_pixel_decoder_unit.sv
rtl/core/prpd_checker.sv
verif/tb.sv
